FILE: rtl/matrix4x4_multiply_defines.svh
// Assertion macros used by the checker module of the matrix multiply block.
// Depends on nothing; each macro expects clk and rst_n in the enclosing scope.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MM4X4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MM4X4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mm4x4_pkg.sv
// Shared constants, word types and control structs of the 4x4 matrix multiply.
// Depends on nothing; the MAC, sequencer, top level and checker import it.
package mm4x4_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ELEM_W      = 32;
    localparam int KIND_W      = 2;
    localparam int DIM         = 4;
    localparam int DIM_W       = $clog2(DIM);
    localparam int ELEM_COUNT  = DIM * DIM;
    localparam int INDEX_W     = $clog2(ELEM_COUNT);
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int ACC_W       = PROD_W + DIM_W;

    localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [INDEX_W-1:0]       elem_index;
        logic signed [ELEM_W-1:0] elem_value;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0]            out_index;
        logic signed [VALUE_WIDTH-1:0] out_value;
        logic                          saturated;
        logic                          last;
    } out_word_t;

    // One multiply-accumulate step issued by the sequencer.
    typedef struct packed {
        logic valid;
        logic first;
    } issue_t;

    // Request to load a finished element into the output register.
    typedef struct packed {
        logic               load;
        logic [INDEX_W-1:0] index;
        logic               last;
    } emit_t;

endpackage

FILE: rtl/mm4x4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mm4x4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mm4x4_mac.sv
// Shared multiply-accumulate unit with the final shift and saturation.
// Depends on mm4x4_pkg; fed by the two store RAMs and the sequencer.
module mm4x4_mac
    import mm4x4_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  issue_t                        issue,
    input  logic signed [VALUE_WIDTH-1:0] left_data,
    input  logic signed [VALUE_WIDTH-1:0] right_data,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic                          saturated
);

    logic                     rd_valid_reg;
    logic                     rd_first_reg;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;

    // Tags follow the RAM read latency and the multiplier register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= issue.valid;
            rd_first_reg   <= issue.first;
            prod_valid_reg <= rd_valid_reg;
            prod_first_reg <= rd_first_reg;
        end
    end

    assign prod_next = PROD_W'(left_data) * PROD_W'(right_data);

    always_comb
    begin
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            if (prod_first_reg)
            begin
                acc_next = ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // The arithmetic shift floors toward minus infinity.
    assign shifted   = acc_reg >>> FRAC_BITS;
    assign fits      = (&shifted[ACC_W-1:VALUE_WIDTH-1]) | ~(|shifted[ACC_W-1:VALUE_WIDTH-1]);
    assign saturated = ~fits;

    always_comb
    begin
        if (fits)
        begin
            result = shifted[VALUE_WIDTH-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            result = VALUE_MIN;
        end
        else
        begin
            result = VALUE_MAX;
        end
    end

endmodule

FILE: rtl/mm4x4_seq.sv
// Sequencer that walks the sixteen product elements and their four terms.
// Depends on mm4x4_pkg; drives the RAM read addresses and the MAC unit.
module mm4x4_seq
    import mm4x4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [KIND_W-1:0]  in_kind,
    input  logic               out_free,
    output logic               in_ready,
    output logic [INDEX_W-1:0] left_raddr,
    output logic [INDEX_W-1:0] right_raddr,
    output issue_t             issue,
    output emit_t              emit
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [INDEX_W-1:0] pos_reg;
    logic [INDEX_W-1:0] pos_next;
    logic [DIM_W-1:0]   k_reg;
    logic [DIM_W-1:0]   k_next;
    logic               drain_reg;
    logic               drain_next;
    logic               pos_last;

    assign pos_last = (pos_reg == INDEX_W'(ELEM_COUNT - 1));

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        drain_next  = drain_reg;
        issue.valid = 1'b0;
        issue.first = 1'b0;
        emit.load   = 1'b0;
        emit.index  = pos_reg;
        emit.last   = pos_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_kind == KIND_COMPUTE))
                begin
                    state_next = ST_ISSUE;
                    pos_next   = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                k_next      = DIM_W'(k_reg + 1'b1);
                if (k_reg == DIM_W'(DIM - 1))
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    emit.load = 1'b1;
                    if (pos_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = INDEX_W'(pos_reg + 1'b1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign left_raddr  = {pos_reg[INDEX_W-1:DIM_W], k_reg};
    assign right_raddr = {k_reg, pos_reg[DIM_W-1:0]};

endmodule

FILE: rtl/matrix4x4_multiply.sv
// Top level of the 4x4 signed fixed-point matrix multiply.
// Depends on mm4x4_pkg, mm4x4_ram, mm4x4_mac and mm4x4_seq.
//
// Channel   Direction  Handshake           Word
// -------   ---------  ------------------  -----------------------------------
// input     in         in_valid/in_ready   in_word: kind, elem_index, elem_value
// output    out        out_valid/out_ready out_word: index, value, sat, last
//
// A load word writes one element of the left or right store.
// A compute word keeps in_ready low while the sixteen elements are formed: each
// element runs on the one shared multiplier (four terms issued, a drain step
// for the RAM read and multiply registers, a final step to hand it to the output
// register), and any output stall lengthens a run. Reset clears the sequencer
// and the output valid; the stores hold nothing meaningful until loaded. A
// back-pressured output only holds the sequencer in its final step, and the
// block takes a new word while the last element waits.
module matrix4x4_multiply
    import mm4x4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic                          in_accept;
    logic                          left_we;
    logic                          right_we;
    logic [VALUE_WIDTH-1:0]        store_wdata;
    logic [INDEX_W-1:0]            left_raddr;
    logic [INDEX_W-1:0]            right_raddr;
    logic [VALUE_WIDTH-1:0]        left_rdata;
    logic [VALUE_WIDTH-1:0]        right_rdata;
    issue_t                        issue;
    emit_t                         emit;
    logic signed [VALUE_WIDTH-1:0] mac_result;
    logic                          mac_saturated;
    logic                          out_free;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    out_word_t                     out_word_reg;
    out_word_t                     out_word_next;

    // Loads go straight into the stores; kind 3 is accepted and dropped.
    assign in_accept   = in_valid & in_ready;
    assign left_we     = in_accept & (in_word.kind == KIND_LOAD_LEFT);
    assign right_we    = in_accept & (in_word.kind == KIND_LOAD_RIGHT);
    assign store_wdata = VALUE_WIDTH'(in_word.elem_value);

    mm4x4_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ELEM_COUNT)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (in_word.elem_index),
        .wdata (store_wdata),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    mm4x4_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ELEM_COUNT)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (in_word.elem_index),
        .wdata (store_wdata),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    // The output register is free when empty or being drained this cycle.
    assign out_free = ~out_valid_reg | out_ready;

    mm4x4_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_kind     (in_word.kind),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .left_raddr  (left_raddr),
        .right_raddr (right_raddr),
        .issue       (issue),
        .emit        (emit)
    );

    mm4x4_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .left_data  (left_rdata),
        .right_data (right_rdata),
        .result     (mac_result),
        .saturated  (mac_saturated)
    );

    // The sequencer only loads when the register is free, so no word is lost.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit.load)
        begin
            out_valid_next          = 1'b1;
            out_word_next.out_index = emit.index;
            out_word_next.out_value = mac_result;
            out_word_next.saturated = mac_saturated;
            out_word_next.last      = emit.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: rtl/mm4x4_checker.sv
// Port-level checker for the matrix multiply top level, bound to it below.
// Depends on mm4x4_pkg and matrix4x4_multiply_defines.svh.
`include "matrix4x4_multiply_defines.svh"

module mm4x4_checker
    import mm4x4_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // A stalled output word must hold.
    `MM4X4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")

    // While a run is still emitting, no new word is taken.
    `MM4X4_ASSERT_NOW(a_busy_in_run, out_valid && !out_word.last, !in_ready, "input taken in the middle of a product run")

    // The last flag marks exactly the final element position.
    `MM4X4_ASSERT_NOW(a_last_pos, out_valid, out_word.last == (out_word.out_index == INDEX_W'(ELEM_COUNT - 1)), "last flag on the wrong element")

    // A clipped element carries one of the two range limits.
    `MM4X4_ASSERT_NOW(a_sat_limit, out_valid && out_word.saturated, (out_word.out_value == VALUE_MAX) || (out_word.out_value == VALUE_MIN), "saturated element not at a limit")

endmodule

bind matrix4x4_multiply mm4x4_checker u_checker (.*);
